// ===== rtl/u8e_pkg.sv =====
// Package for the UTF-8 encoder with byte budget.
// Widths, register indexes, encoding constants and the queue entry type.
// No dependencies.
package u8e_pkg;

	localparam int CP_W        = 31;
	localparam int BUDGET_W    = 16;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BUDGET_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BYTE_BUDGET   = 1'd1;

	localparam logic [CP_W-1:0] MAX_1B = 31'h7F;
	localparam logic [CP_W-1:0] MAX_2B = 31'h7FF;
	localparam logic [CP_W-1:0] MAX_3B = 31'hFFFF;
	localparam logic [CP_W-1:0] MAX_CP = 31'h10FFFF;

	localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
	localparam logic [BYTE_W-1:0] CONT_B  = 8'h80;
	localparam logic [BYTE_W-1:0] CONT_M  = 8'h3F;

	typedef logic [LEN_W-1:0] len_t;

	// One queued item: bytes left-aligned, count of results, end marker flag
	typedef struct packed {
		logic [4*BYTE_W-1:0] bytes;
		len_t                count;
		logic                endm;
	} chr_t;

endpackage

// ===== rtl/u8e_if.sv =====
// Channel interfaces for the UTF-8 encoder: input, result and configuration.
// Depends on u8e_pkg.
interface u8e_in_if import u8e_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            string_start;
	modport source (output valid, code_point, string_start, input ready);
	modport sink (input valid, code_point, string_start, output ready);
endinterface

interface u8e_out_if import u8e_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              end_marker;
	logic              last_of_char;
	modport source (output valid, out_byte, end_marker, last_of_char, input ready);
	modport sink (input valid, out_byte, end_marker, last_of_char, output ready);
endinterface

interface u8e_cfg_if import u8e_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/u8e_front.sv =====
// Front end: configuration registers, string state and code point classification.
// Pushes one queue entry per item that yields results. Depends on u8e_pkg, u8e_if.
module u8e_front import u8e_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	u8e_in_if.sink       in_ch,
	u8e_cfg_if.sink      cfg,
	input  logic         q_full,
	output logic         push,
	output chr_t         push_entry
);

	logic                budget_en_q;
	logic [BUDGET_W-1:0] budget_q;
	logic [BUDGET_W-1:0] bytes_left_q;
	logic                stopped_q;

	logic                accept;
	logic [BUDGET_W-1:0] left_eff;
	logic                stopped_eff;
	logic [CP_W-1:0]     cp;
	len_t                len;
	logic                fits;
	logic [BYTE_W-1:0]   b0, b1, b2, b3;
	logic [4*BYTE_W-1:0] enc;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign cp          = in_ch.code_point;

	assign left_eff    = in_ch.string_start ? budget_q : bytes_left_q;
	assign stopped_eff = in_ch.string_start ? 1'b0 : stopped_q;

	always_comb begin
		if (cp == '0 || cp > MAX_CP)
			len = len_t'(0);
		else if (cp <= MAX_1B)
			len = len_t'(1);
		else if (cp <= MAX_2B)
			len = len_t'(2);
		else if (cp <= MAX_3B)
			len = len_t'(3);
		else
			len = len_t'(4);
	end

	assign fits = (len != '0) &&
		(!budget_en_q || {{(BUDGET_W-LEN_W){1'b0}}, len} <= left_eff);

	assign b3 = CONT_B | (cp[7:0] & CONT_M);
	assign b2 = CONT_B | (cp[13:6] & CONT_M);
	assign b1 = CONT_B | (cp[19:12] & CONT_M);

	always_comb begin
		b0  = '0;
		enc = '0;
		case (len)
			len_t'(1): enc = {cp[7:0], 24'd0};
			len_t'(2): begin
				b0  = LEAD_2B | {3'd0, cp[10:6]};
				enc = {b0, b3, 16'd0};
			end
			len_t'(3): begin
				b0  = LEAD_3B | {4'd0, cp[15:12]};
				enc = {b0, b2, b3, 8'd0};
			end
			len_t'(4): begin
				b0  = LEAD_4B | {5'd0, cp[20:18]};
				enc = {b0, b1, b2, b3};
			end
			default: enc = '0;
		endcase
	end

	assign push = accept && !stopped_eff;

	always_comb begin
		push_entry.bytes = fits ? enc : '0;
		push_entry.count = fits ? len : len_t'(1);
		push_entry.endm  = !fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_en_q  <= 1'b0;
			budget_q     <= '0;
			bytes_left_q <= '0;
			stopped_q    <= 1'b1;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BUDGET_ENABLE: budget_en_q <= cfg.data[0];
					REG_BYTE_BUDGET:   budget_q    <= cfg.data[BUDGET_W-1:0];
					default: ;
				endcase
			end
			// a silent item leaves the string state as it is
			if (accept && !stopped_eff) begin
				stopped_q <= !fits;
				if (fits && budget_en_q)
					bytes_left_q <= left_eff - {{(BUDGET_W-LEN_W){1'b0}}, len};
				else
					bytes_left_q <= left_eff;
			end
		end
	end

endmodule

// ===== rtl/u8e_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on u8e_pkg.
module u8e_queue import u8e_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  chr_t push_entry,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output chr_t q_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	chr_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_entry = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== rtl/u8e_back.sv =====
// Back end: takes queued items and emits their bytes one per cycle while out_ch is ready.
// Output register holds the current item. Depends on u8e_pkg, u8e_if.
module u8e_back import u8e_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  chr_t     q_entry,
	output logic     pop,
	u8e_out_if.source out_ch
);

	logic                busy_q;
	logic [4*BYTE_W-1:0] bytes_q;
	len_t                cnt_q;
	logic                endm_q;
	logic                last;
	logic                fire;
	logic                take;

	assign last                = (cnt_q == len_t'(1));
	assign out_ch.valid        = busy_q;
	assign out_ch.out_byte     = bytes_q[4*BYTE_W-1 -: BYTE_W];
	assign out_ch.end_marker   = endm_q;
	assign out_ch.last_of_char = last;

	assign fire = out_ch.valid && out_ch.ready;
	assign take = !busy_q || (fire && last);
	assign pop  = take && q_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			bytes_q <= q_entry.bytes;
			cnt_q   <= q_entry.count;
			endm_q  <= q_entry.endm;
		end else if (fire && !last) begin
			bytes_q <= {bytes_q[3*BYTE_W-1:0], {BYTE_W{1'b0}}};
			cnt_q   <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (take)
			busy_q <= q_valid;
	end

endmodule

// ===== rtl/utf8_encoder_with_byte_budget.sv =====
// UTF-8 encoder with a per-string byte budget: top level.
// Connects front end, item queue and back end. Depends on u8e_pkg, u8e_if and submodules.
//
// in_ch takes one code point per item with string_start marking a string's first
// character (which reloads the budget). out_ch gives one result per byte, 1 to 4
// per item, last_of_char on the final one; a string end (code point 0, a value
// above 0x10FFFF, or a character that does not fit the budget) gives one
// end_marker result, after which items are dropped until string_start.
// cfg writes budget_enable (index 0) and byte_budget (index 1); ready is always
// high. Write only while idle.
// The first byte of an item passes through the queue and then the output register
// when the back end is free. out_ch gives one result per cycle while the receiver
// is ready, as set by the back end's byte sequencer.
// A queue of QUEUE_DEPTH items lets the front keep taking items while the
// receiver stalls; once it is full in_ch.ready drops. Items that yield no
// result are taken at one per cycle while the queue is not full.
// Reset clears configuration and the queue and leaves the block silent until
// a string starts.
module utf8_encoder_with_byte_budget import u8e_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	u8e_in_if.sink    in_ch,
	u8e_cfg_if.sink   cfg,
	u8e_out_if.source out_ch
);

	logic push, full, pop, q_valid;
	chr_t push_entry, q_entry;

	u8e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg),
		.q_full     (full),
		.push       (push),
		.push_entry (push_entry)
	);

	u8e_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.q_valid    (q_valid),
		.q_entry    (q_entry)
	);

	u8e_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== test/utf8_encoder_with_byte_budget_checker.sv =====
// Checker for the UTF-8 encoder with byte budget: watches the input, configuration
// and result channels, predicts each item's bytes and compares them in order.
// Depends on u8e_pkg and u8e_if.
module utf8_encoder_with_byte_budget_checker import u8e_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	u8e_in_if    in_ch,
	u8e_cfg_if   cfg,
	u8e_out_if   out_ch,
	output int   n_fail,
	output int   n_pending,
	output int   n_chars
);

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              end_marker;
		logic              last_of_char;
	} utf8_res_t;

	utf8_res_t             byte_q[$];
	logic                  limit_on;
	logic [BUDGET_W-1:0]   budget;
	logic [BUDGET_W-1:0]   bytes_left;
	logic                  silent;

	function automatic logic [BYTE_W-1:0] cont_byte(input logic [CP_W-1:0] cp, input int sh);
		return CONT_B | (BYTE_W'(cp >> sh) & CONT_M);
	endfunction

	function automatic void predict_bytes(input logic [CP_W-1:0] cp, input logic start);
		int unsigned       nb;
		logic [BYTE_W-1:0] b[4];
		if (start) begin
			bytes_left = budget;
			silent     = 1'b0;
		end
		if (silent)
			return;
		n_chars++;
		if (cp == '0 || cp > MAX_CP)
			nb = 0;
		else if (cp <= MAX_1B)
			nb = 1;
		else if (cp <= MAX_2B)
			nb = 2;
		else if (cp <= MAX_3B)
			nb = 3;
		else
			nb = 4;
		if (nb != 0 && limit_on && nb > bytes_left)
			nb = 0;
		if (nb == 0) begin
			silent = 1'b1;
			byte_q.push_back('{out_byte: '0, end_marker: 1'b1, last_of_char: 1'b1});
			return;
		end
		case (nb)
			1: b[0] = cp[BYTE_W-1:0];
			2: begin
				b[0] = LEAD_2B | BYTE_W'(cp >> 6);
				b[1] = cont_byte(cp, 0);
			end
			3: begin
				b[0] = LEAD_3B | BYTE_W'(cp >> 12);
				b[1] = cont_byte(cp, 6);
				b[2] = cont_byte(cp, 0);
			end
			default: begin
				b[0] = LEAD_4B | BYTE_W'(cp >> 18);
				b[1] = cont_byte(cp, 12);
				b[2] = cont_byte(cp, 6);
				b[3] = cont_byte(cp, 0);
			end
		endcase
		if (limit_on)
			bytes_left = bytes_left - BUDGET_W'(nb);
		for (int k = 0; k < nb; k++)
			byte_q.push_back('{out_byte: b[k], end_marker: 1'b0, last_of_char: k == nb - 1});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		utf8_res_t want;
		if (!arst_n) begin
			byte_q.delete();
			limit_on   = 1'b0;
			budget     = '0;
			bytes_left = '0;
			silent     = 1'b1;
			n_fail     = 0;
			n_pending  = 0;
			n_chars    = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BUDGET_ENABLE: limit_on = cfg.data[0];
					REG_BYTE_BUDGET:   budget   = cfg.data;
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (byte_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected result: byte %02h end %0b last %0b",
							out_ch.out_byte, out_ch.end_marker, out_ch.last_of_char);
				end else begin
					want = byte_q.pop_front();
					if (want.out_byte !== out_ch.out_byte || want.end_marker !== out_ch.end_marker ||
							want.last_of_char !== out_ch.last_of_char) begin
						n_fail++;
						if (n_fail <= 10)
							$display("mismatch: expected byte %02h end %0b last %0b, got byte %02h end %0b last %0b",
								want.out_byte, want.end_marker, want.last_of_char,
								out_ch.out_byte, out_ch.end_marker, out_ch.last_of_char);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_bytes(in_ch.code_point, in_ch.string_start);
			n_pending = byte_q.size();
		end
	end

endmodule

// ===== test/utf8_encoder_with_byte_budget_test.sv =====
// Testbench top for the UTF-8 encoder with byte budget: clock, reset, stimulus
// and verdict; checking is done by utf8_encoder_with_byte_budget_checker.
// Depends on u8e_pkg, u8e_if, the block and the checker.
module utf8_encoder_with_byte_budget_test import u8e_pkg::*; ();

	localparam int LONG_HOLD     = 60;
	localparam int SETTLE_CYCLES = 8;
	localparam int N_PHASES      = 10;
	localparam int PHASE_CHARS   = 35;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int          n_fail;
	int          n_pending;
	int          n_chars;
	int unsigned tx_mode = 0;
	int unsigned rx_mode = 0;
	int          hold_asks = 0;
	int          hold_done = 0;

	u8e_in_if  in_ch ();
	u8e_out_if out_ch ();
	u8e_cfg_if cfg_ch ();

	utf8_encoder_with_byte_budget i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_ch),
		.out_ch (out_ch)
	);

	utf8_encoder_with_byte_budget_checker i_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg_ch),
		.out_ch    (out_ch),
		.n_fail    (n_fail),
		.n_pending (n_pending),
		.n_chars   (n_chars)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("utf8_encoder_with_byte_budget_test failed");
		$finish;
	end

	function automatic int unsigned draw_gap(input int unsigned mode);
		case (mode)
			0: return 0;
			1: return $urandom_range(0, 18);
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
		endcase
	endfunction

	function automatic logic [CP_W-1:0] pick_code_point();
		int unsigned sel = $urandom_range(0, 99);
		if (sel < 30)
			return CP_W'($urandom_range(1, 'h7F));
		if (sel < 50)
			return CP_W'($urandom_range('h80, 'h7FF));
		if (sel < 68)
			return CP_W'($urandom_range('h800, 'hFFFF));
		if (sel < 73)
			return CP_W'($urandom_range('hD800, 'hDFFF));
		if (sel < 88)
			return CP_W'($urandom_range('h10000, 'h10FFFF));
		if (sel < 94)
			return CP_W'($urandom_range('h110000, 'h7FFFFFFF));
		return CP_W'($urandom);
	endfunction

	task automatic send_char(input logic [CP_W-1:0] cp, input logic start);
		int unsigned gap;
		gap = draw_gap(tx_mode);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.code_point   <= cp;
		in_ch.string_start <= start;
		in_ch.valid        <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	task automatic configure(input logic on, input logic [BUDGET_W-1:0] budget);
		write_reg(REG_BUDGET_ENABLE, {(CFG_DATA_W-1)'($urandom), on});
		write_reg(REG_BYTE_BUDGET, CFG_DATA_W'(budget));
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		while (n_pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_string();
		int unsigned      len;
		logic [CP_W-1:0]  cp;
		len = $urandom_range(1, 8);
		for (int k = 0; k < len; k++) begin
			cp = pick_code_point();
			if (k == len - 1 && $urandom_range(0, 2) != 0)
				cp = '0;
			send_char(cp, k == 0);
		end
	endtask

	initial begin : rx_side
		int unsigned gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_done != hold_asks) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_done++;
			end
			gap = draw_gap(rx_mode);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	initial begin : stimulus
		int target;
		int strings;
		in_ch.valid         = 1'b0;
		in_ch.code_point    = '0;
		in_ch.string_start  = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = '0;
		cfg_ch.data         = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_mode = 1;
		rx_mode = 1;
		configure(1'b0, 16'hA5C3);
		// silent after reset, then every length boundary, surrogates and invalid values
		send_char(31'h41, 1'b0);
		send_char(31'h41, 1'b1);
		send_char(31'h7F, 1'b0);
		send_char(31'h80, 1'b0);
		send_char(31'h7FF, 1'b0);
		send_char(31'h800, 1'b0);
		send_char(31'hD800, 1'b0);
		send_char(31'hDFFF, 1'b0);
		send_char(31'hFFFF, 1'b0);
		send_char(31'h10000, 1'b0);
		send_char(31'h10FFFF, 1'b0);
		send_char(31'h1, 1'b0);
		send_char(31'h0, 1'b0);
		send_char(31'h42, 1'b0);
		send_char(31'h110000, 1'b1);
		send_char(31'h7FFFFFFF, 1'b1);
		send_char(31'h2A, 1'b1);
		send_char(31'h3C1, 1'b0);
		settle();
		// zero budget
		configure(1'b1, 16'h0000);
		send_char(31'h41, 1'b1);
		send_char(31'h41, 1'b0);
		settle();
		// exact fit, then overflow
		configure(1'b1, 16'd6);
		send_char(31'h10FFFF, 1'b1);
		send_char(31'h7FF, 1'b0);
		send_char(31'h41, 1'b0);
		send_char(31'h800, 1'b1);
		send_char(31'h800, 1'b0);
		send_char(31'h20, 1'b0);
		settle();
		// budget switched on mid string uses the last loaded value
		configure(1'b0, 16'd3);
		send_char(31'h41, 1'b1);
		send_char(31'h10000, 1'b0);
		settle();
		configure(1'b1, 16'd3);
		send_char(31'h800, 1'b0);
		send_char(31'h41, 1'b0);
		settle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph % 5)
				0: configure(1'b0, BUDGET_W'($urandom));
				1: configure(1'b1, BUDGET_W'($urandom_range(0, 16)));
				2: configure(1'b1, BUDGET_W'($urandom_range(17, 300)));
				3: configure(1'b1, 16'hFFFF);
				default: configure(1'b1, BUDGET_W'($urandom));
			endcase
			if (ph == 0) begin
				tx_mode = 0;
				rx_mode = 0;
			end else begin
				tx_mode = $urandom_range(0, 2);
				rx_mode = $urandom_range(0, 2);
			end
			if (ph == 2)
				hold_asks++;
			target  = n_chars + PHASE_CHARS;
			strings = 0;
			while (n_chars < target) begin
				if ($urandom_range(0, 99) < 15)
					send_char(CP_W'($urandom), $urandom_range(0, 1));
				else
					send_string();
				strings++;
				if (ph == 6 && strings == 3)
					settle();
			end
			settle();
		end

		if (n_fail == 0)
			$display("utf8_encoder_with_byte_budget_test passed");
		else
			$display("utf8_encoder_with_byte_budget_test failed");
		$finish;
	end

endmodule
